// ===== hw/rtl/trd_pkg.sv =====
`default_nettype none

package trd_pkg;

    // header layout and format codes
    localparam logic [4:0] HEADER_LAST = 5'd17;
    localparam logic [4:0] POS_ID_LEN  = 5'd0;
    localparam logic [4:0] POS_CMAP    = 5'd1;
    localparam logic [4:0] POS_TYPE    = 5'd2;
    localparam logic [4:0] POS_W_LO    = 5'd12;
    localparam logic [4:0] POS_W_HI    = 5'd13;
    localparam logic [4:0] POS_H_LO    = 5'd14;
    localparam logic [4:0] POS_H_HI    = 5'd15;
    localparam logic [4:0] POS_DEPTH   = 5'd16;

    localparam logic [7:0] TYPE_RAW    = 8'd2;
    localparam logic [7:0] TYPE_RLE    = 8'd10;
    localparam logic [7:0] DEPTH_RGB   = 8'd24;
    localparam logic [7:0] DEPTH_RGBA  = 8'd32;
    localparam logic [7:0] RAW_LIMIT   = 8'd128;
    localparam logic [7:0] REPEAT_BIAS = 8'd127;
    localparam logic [7:0] OPAQUE      = 8'd255;

    // parser phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    // result kind
    typedef enum logic [1:0] {
        ST_RUN,
        ST_UNSUPPORTED,
        ST_EMPTY
    } status_t;

    // component position within a pixel
    typedef enum logic [1:0] {
        CI_BLUE,
        CI_GREEN,
        CI_RED,
        CI_ALPHA
    } comp_t;

    // one result word
    typedef struct packed {
        status_t     status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_length;
        logic        image_done;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

    // input word as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trd_in_stage.sv =====
`default_nettype none

module trd_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire trd_pkg::in_word_t in_word,
    input  wire logic             take,
    output logic                  held_valid,
    output trd_pkg::in_word_t     held_word
);

    logic              valid_reg;
    logic              valid_next;
    trd_pkg::in_word_t word_reg;

    // free when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/trd_core.sv =====
`default_nettype none

module trd_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire trd_pkg::in_word_t word,
    output logic                  res_valid,
    output trd_pkg::result_t      res
);

    trd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]      hpos_reg, hpos_next;
    logic [7:0]      skip_reg, skip_next;
    logic            is_rle_reg, is_rle_next;
    logic            has_alpha_reg, has_alpha_next;
    logic            bad_reg, bad_next;
    logic [15:0]     width_reg, width_next;
    logic [15:0]     height_reg, height_next;
    logic [31:0]     pixels_reg, pixels_next;
    logic [7:0]      packet_reg, packet_next;
    logic            repeat_reg, repeat_next;
    trd_pkg::comp_t  ci_reg, ci_next;
    logic [7:0]      blue_reg, blue_next;
    logic [7:0]      green_reg, green_next;
    logic [7:0]      red_reg, red_next;
    logic [31:0]     product_reg;

    // state as seen by this word, after a start mark clears it
    trd_pkg::phase_t cur_phase;
    logic [4:0]      cur_hpos;
    logic [7:0]      cur_skip;
    logic            cur_is_rle;
    logic            cur_has_alpha;
    logic            cur_bad;
    logic [15:0]     cur_width;
    logic [15:0]     cur_height;
    logic [31:0]     cur_pixels;
    logic [7:0]      cur_packet;
    logic            cur_repeat;
    trd_pkg::comp_t  cur_ci;

    logic [7:0]  b;
    logic        hdr_end;
    logic        hdr_reject;
    logic        hdr_empty;
    logic        pkt_header;
    logic        emit;
    logic [7:0]  run_raw;
    logic [7:0]  run;
    logic [31:0] pixels_after;
    logic [7:0]  skip_dec;

    assign b = word.data_byte;

    always_comb begin
        if (word.file_start) begin
            cur_phase     = trd_pkg::PH_HEADER;
            cur_hpos      = '0;
            cur_skip      = '0;
            cur_is_rle    = 1'b0;
            cur_has_alpha = 1'b0;
            cur_bad       = 1'b0;
            cur_width     = '0;
            cur_height    = '0;
            cur_pixels    = '0;
            cur_packet    = '0;
            cur_repeat    = 1'b0;
            cur_ci        = trd_pkg::CI_BLUE;
        end else begin
            cur_phase     = phase_reg;
            cur_hpos      = hpos_reg;
            cur_skip      = skip_reg;
            cur_is_rle    = is_rle_reg;
            cur_has_alpha = has_alpha_reg;
            cur_bad       = bad_reg;
            cur_width     = width_reg;
            cur_height    = height_reg;
            cur_pixels    = pixels_reg;
            cur_packet    = packet_reg;
            cur_repeat    = repeat_reg;
            cur_ci        = ci_reg;
        end
    end

    // decisions shared by phase and datapath logic
    assign hdr_end    = (cur_phase == trd_pkg::PH_HEADER) && (cur_hpos == trd_pkg::HEADER_LAST);
    assign hdr_reject = hdr_end && cur_bad;
    assign hdr_empty  = hdr_end && !cur_bad && ((cur_width == 16'd0) || (cur_height == 16'd0));
    assign pkt_header = (cur_phase == trd_pkg::PH_PIXELS) && cur_is_rle
                        && (cur_packet == 8'd0);
    assign emit       = (cur_phase == trd_pkg::PH_PIXELS) && !pkt_header
                        && (((cur_ci == trd_pkg::CI_RED) && !cur_has_alpha)
                            || (cur_ci == trd_pkg::CI_ALPHA));
    assign skip_dec   = (cur_skip != 8'd0) ? cur_skip - 8'd1 : cur_skip;

    // run length, clamped to the pixels left
    assign run_raw      = (cur_is_rle && cur_repeat) ? cur_packet : 8'd1;
    assign run          = ({24'd0, run_raw} > cur_pixels) ? cur_pixels[7:0] : run_raw;
    assign pixels_after = cur_pixels - {24'd0, run};

    // next phase
    always_comb begin
        phase_next = cur_phase;
        unique case (cur_phase)
            trd_pkg::PH_HEADER: begin
                if (hdr_reject || hdr_empty) begin
                    phase_next = trd_pkg::PH_IDLE;
                end else if (hdr_end) begin
                    phase_next = (cur_skip != 8'd0) ? trd_pkg::PH_SKIP : trd_pkg::PH_PIXELS;
                end
            end
            trd_pkg::PH_SKIP: begin
                if (skip_dec == 8'd0) begin
                    phase_next = trd_pkg::PH_PIXELS;
                end
            end
            trd_pkg::PH_PIXELS: begin
                if (emit && (pixels_after == 32'd0)) begin
                    phase_next = trd_pkg::PH_IDLE;
                end
            end
            trd_pkg::PH_IDLE: begin
                phase_next = trd_pkg::PH_IDLE;
            end
            default: begin
                phase_next = trd_pkg::PH_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        hpos_next      = cur_hpos;
        skip_next      = cur_skip;
        is_rle_next    = cur_is_rle;
        has_alpha_next = cur_has_alpha;
        bad_next       = cur_bad;
        width_next     = cur_width;
        height_next    = cur_height;
        pixels_next    = cur_pixels;
        packet_next    = cur_packet;
        repeat_next    = cur_repeat;
        ci_next        = cur_ci;
        blue_next      = blue_reg;
        green_next     = green_reg;
        red_next       = red_reg;
        if (word.file_start) begin
            blue_next  = '0;
            green_next = '0;
            red_next   = '0;
        end

        res_valid        = 1'b0;
        res.status       = trd_pkg::ST_RUN;
        res.red          = '0;
        res.green        = '0;
        res.blue         = '0;
        res.alpha        = '0;
        res.run_length   = '0;
        res.image_done   = 1'b0;

        unique case (cur_phase)
            trd_pkg::PH_HEADER: begin
                unique case (cur_hpos)
                    trd_pkg::POS_ID_LEN: skip_next = b;
                    trd_pkg::POS_CMAP: begin
                        if (b != 8'd0) begin
                            bad_next = 1'b1;
                        end
                    end
                    trd_pkg::POS_TYPE: begin
                        is_rle_next = (b == trd_pkg::TYPE_RLE);
                        if ((b != trd_pkg::TYPE_RAW) && (b != trd_pkg::TYPE_RLE)) begin
                            bad_next = 1'b1;
                        end
                    end
                    trd_pkg::POS_W_LO: width_next  = {cur_width[15:8], b};
                    trd_pkg::POS_W_HI: width_next  = {b, cur_width[7:0]};
                    trd_pkg::POS_H_LO: height_next = {cur_height[15:8], b};
                    trd_pkg::POS_H_HI: height_next = {b, cur_height[7:0]};
                    trd_pkg::POS_DEPTH: begin
                        has_alpha_next = (b == trd_pkg::DEPTH_RGBA);
                        if ((b != trd_pkg::DEPTH_RGB) && (b != trd_pkg::DEPTH_RGBA)) begin
                            bad_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!hdr_end) begin
                    hpos_next = cur_hpos + 5'd1;
                end else if (hdr_reject) begin
                    res_valid  = 1'b1;
                    res.status = trd_pkg::ST_UNSUPPORTED;
                end else if (hdr_empty) begin
                    pixels_next    = '0;
                    res_valid      = 1'b1;
                    res.status     = trd_pkg::ST_EMPTY;
                    res.image_done = 1'b1;
                end else begin
                    pixels_next = product_reg;
                end
            end
            trd_pkg::PH_SKIP: begin
                skip_next = skip_dec;
            end
            trd_pkg::PH_PIXELS: begin
                if (pkt_header) begin
                    if (b < trd_pkg::RAW_LIMIT) begin
                        repeat_next = 1'b0;
                        packet_next = b + 8'd1;
                    end else begin
                        repeat_next = 1'b1;
                        packet_next = b - trd_pkg::REPEAT_BIAS;
                    end
                end else begin
                    unique case (cur_ci)
                        trd_pkg::CI_BLUE: begin
                            blue_next = b;
                            ci_next   = trd_pkg::CI_GREEN;
                        end
                        trd_pkg::CI_GREEN: begin
                            green_next = b;
                            ci_next    = trd_pkg::CI_RED;
                        end
                        trd_pkg::CI_RED: begin
                            red_next = b;
                            ci_next  = trd_pkg::CI_ALPHA;
                        end
                        trd_pkg::CI_ALPHA: begin
                        end
                        default: begin
                        end
                    endcase
                    if (emit) begin
                        if (cur_is_rle && cur_repeat) begin
                            packet_next = 8'd0;
                        end else if (cur_is_rle && (cur_packet != 8'd0)) begin
                            packet_next = cur_packet - 8'd1;
                        end
                        pixels_next    = pixels_after;
                        ci_next        = trd_pkg::CI_BLUE;
                        res_valid      = 1'b1;
                        res.red        = (cur_ci == trd_pkg::CI_RED) ? b : red_reg;
                        res.green      = green_reg;
                        res.blue       = blue_reg;
                        res.alpha      = (cur_ci == trd_pkg::CI_ALPHA) ? b : trd_pkg::OPAQUE;
                        res.run_length = run;
                        res.image_done = (pixels_after == 32'd0);
                    end
                end
            end
            trd_pkg::PH_IDLE: begin
            end
            default: begin
            end
        endcase

        res.image_width  = width_next;
        res.image_height = height_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= trd_pkg::PH_HEADER;
            hpos_reg      <= '0;
            skip_reg      <= '0;
            is_rle_reg    <= 1'b0;
            has_alpha_reg <= 1'b0;
            bad_reg       <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            pixels_reg    <= '0;
            packet_reg    <= '0;
            repeat_reg    <= 1'b0;
            ci_reg        <= trd_pkg::CI_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            hpos_reg      <= hpos_next;
            skip_reg      <= skip_next;
            is_rle_reg    <= is_rle_next;
            has_alpha_reg <= has_alpha_next;
            bad_reg       <= bad_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            pixels_reg    <= pixels_next;
            packet_reg    <= packet_next;
            repeat_reg    <= repeat_next;
            ci_reg        <= ci_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            red_reg       <= red_next;
        end
    end

    // pixel count, registered; dimensions settle two words before the header ends
    always_ff @(posedge aclk) begin
        product_reg <= width_reg * height_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trd_out_stage.sv =====
`default_nettype none

module trd_out_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire trd_pkg::result_t res,
    output logic                 can_take,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output trd_pkg::result_t     out_res
);

    logic             valid_reg;
    logic             valid_next;
    trd_pkg::result_t res_reg;

    // slot is free when empty or emptied this cycle
    assign can_take = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tga_rle_decoder.sv =====
// path: accepted byte -> input register -> parser step -> result register
// throughput: one byte per cycle while the result slot can take a word, set
//   by the single-pass parser step between the input and result registers
// reset: aresetn low at a clock edge empties both registers and returns the
//   parser to header byte 0 with all held fields cleared
`default_nettype none

module tga_rle_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // file_start[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // red, green, blue, alpha, run_length,
                                        // image_width[55:40], image_height[71:56]
    output logic [1:0]       m_tuser,   // status[1:0]
    output logic             m_tlast    // image_done
);

    trd_pkg::in_word_t in_word;
    trd_pkg::in_word_t held_word;
    trd_pkg::result_t  res;
    trd_pkg::result_t  out_res;
    logic              held_valid;
    logic              can_take;
    logic              fire;
    logic              res_valid;

    assign in_word.data_byte  = s_tdata;
    assign in_word.file_start = s_tuser;

    // a held word is processed when the result slot can take its word
    assign fire = held_valid && can_take;

    trd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (in_word),
        .take       (fire),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    trd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .word      (held_word),
        .res_valid (res_valid),
        .res       (res)
    );

    trd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    // pack the result word
    assign m_tdata = {out_res.image_height, out_res.image_width, out_res.run_length,
                      out_res.alpha, out_res.blue, out_res.green, out_res.red};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.image_done;

endmodule

`default_nettype wire

// ===== sim/trd_checker.sv =====
module trd_checker
    import trd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // file_start[0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,   // red, green, blue, alpha, run_length,
                                        // image_width[55:40], image_height[71:56]
    input  wire logic [1:0]  m_tuser,   // status[1:0]
    input  wire logic        m_tlast,   // image_done
    output int               error_count,
    output int               words_due,
    output int               runs_seen,
    output int               rejects_seen,
    output int               empties_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    // decoder state as predicted
    phase_t      prs_phase;
    logic [4:0]  hdr_pos;
    logic [7:0]  id_left;
    bit          rle_mode;
    bit          alpha_mode;
    bit          hdr_bad;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [31:0] px_left;
    logic [7:0]  pkt_left;
    bit          pkt_repeat;
    comp_t       comp_pos;
    logic [7:0]  blue_q;
    logic [7:0]  green_q;
    logic [7:0]  red_q;

    // result words still owed by the block, oldest first
    result_t decoded_due[$];
    int      fail_total;
    int      run_total;
    int      reject_total;
    int      empty_total;

    initial begin
        error_count  = 0;
        words_due    = 0;
        runs_seen    = 0;
        rejects_seen = 0;
        empties_seen = 0;
        fail_total   = 0;
        run_total    = 0;
        reject_total = 0;
        empty_total  = 0;
    end

    task automatic clear_decoder();
        prs_phase  = PH_HEADER;
        hdr_pos    = '0;
        id_left    = '0;
        rle_mode   = 1'b0;
        alpha_mode = 1'b0;
        hdr_bad    = 1'b0;
        width_q    = '0;
        height_q   = '0;
        px_left    = '0;
        pkt_left   = '0;
        pkt_repeat = 1'b0;
        comp_pos   = CI_BLUE;
        blue_q     = '0;
        green_q    = '0;
        red_q      = '0;
    endtask

    function automatic result_t make_word(status_t st, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b, logic [7:0] a,
                                          logic [7:0] run, logic done);
        result_t w;
        w.status       = st;
        w.red          = r;
        w.green        = g;
        w.blue         = b;
        w.alpha        = a;
        w.run_length   = run;
        w.image_done   = done;
        w.image_width  = width_q;
        w.image_height = height_q;
        return w;
    endfunction

    // one pixel out: repeat packets give their whole count, clamped to the image
    task automatic emit_run(input logic [7:0] a, output result_t w);
        logic [31:0] run;
        run = 32'd1;
        if (rle_mode && pkt_repeat) begin
            run      = {24'd0, pkt_left};
            pkt_left = '0;
        end else if (rle_mode && pkt_left != 0) begin
            pkt_left = pkt_left - 8'd1;
        end
        if (run > px_left) run = px_left;
        px_left  = px_left - run;
        comp_pos = CI_BLUE;
        if (px_left == 0) prs_phase = PH_IDLE;
        w = make_word(ST_RUN, red_q, green_q, blue_q, a, run[7:0], px_left == 0);
    endtask

    task automatic header_step(input logic [7:0] b, output bit got, output result_t w);
        got = 1'b0;
        w   = '0;
        case (hdr_pos)
            POS_ID_LEN: id_left = b;
            POS_CMAP:   if (b != 8'd0) hdr_bad = 1'b1;
            POS_TYPE: begin
                rle_mode = (b == TYPE_RLE);
                if (b != TYPE_RAW && b != TYPE_RLE) hdr_bad = 1'b1;
            end
            POS_W_LO:   width_q[7:0]   = b;
            POS_W_HI:   width_q[15:8]  = b;
            POS_H_LO:   height_q[7:0]  = b;
            POS_H_HI:   height_q[15:8] = b;
            POS_DEPTH: begin
                alpha_mode = (b == DEPTH_RGBA);
                if (b != DEPTH_RGB && b != DEPTH_RGBA) hdr_bad = 1'b1;
            end
            default: ;
        endcase
        if (hdr_pos < HEADER_LAST) begin
            hdr_pos = hdr_pos + 5'd1;
        end else if (hdr_bad) begin
            prs_phase = PH_IDLE;
            got       = 1'b1;
            w         = make_word(ST_UNSUPPORTED, '0, '0, '0, '0, '0, 1'b0);
        end else begin
            px_left = {16'd0, width_q} * {16'd0, height_q};
            if (px_left == 0) begin
                prs_phase = PH_IDLE;
                got       = 1'b1;
                w         = make_word(ST_EMPTY, '0, '0, '0, '0, '0, 1'b1);
            end else begin
                prs_phase = (id_left != 0) ? PH_SKIP : PH_PIXELS;
            end
        end
    endtask

    task automatic pixel_step(input logic [7:0] b, output bit got, output result_t w);
        got = 1'b0;
        w   = '0;
        if (rle_mode && pkt_left == 0) begin
            // packet header: raw below the limit, repeat from it
            if (b < RAW_LIMIT) begin
                pkt_repeat = 1'b0;
                pkt_left   = b + 8'd1;
            end else begin
                pkt_repeat = 1'b1;
                pkt_left   = b - REPEAT_BIAS;
            end
        end else begin
            case (comp_pos)
                CI_BLUE: begin
                    blue_q   = b;
                    comp_pos = CI_GREEN;
                end
                CI_GREEN: begin
                    green_q  = b;
                    comp_pos = CI_RED;
                end
                CI_RED: begin
                    red_q = b;
                    if (!alpha_mode) begin
                        emit_run(OPAQUE, w);
                        got = 1'b1;
                    end else begin
                        comp_pos = CI_ALPHA;
                    end
                end
                default: begin
                    emit_run(b, w);
                    got = 1'b1;
                end
            endcase
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fs,
                               output bit got, output result_t w);
        got = 1'b0;
        w   = '0;
        if (fs) clear_decoder();
        case (prs_phase)
            PH_HEADER: header_step(b, got, w);
            PH_SKIP: begin
                if (id_left != 0) id_left = id_left - 8'd1;
                if (id_left == 0) prs_phase = PH_PIXELS;
            end
            PH_PIXELS: pixel_step(b, got, w);
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    // watch both channels: compare outgoing words first, then predict
    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        bit      got;
        if (!aresetn) begin
            clear_decoder();
            decoded_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen.status       = status_t'(m_tuser);
                seen.red          = m_tdata[7:0];
                seen.green        = m_tdata[15:8];
                seen.blue         = m_tdata[23:16];
                seen.alpha        = m_tdata[31:24];
                seen.run_length   = m_tdata[39:32];
                seen.image_done   = m_tlast;
                seen.image_width  = m_tdata[55:40];
                seen.image_height = m_tdata[71:56];
                if (decoded_due.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none actual status %0d",
                             $time, m_tuser);
                    fail_total++;
                end else begin
                    want = decoded_due.pop_front();
                    check_field("status", 16'(want.status), 16'(seen.status));
                    check_field("red", 16'(want.red), 16'(seen.red));
                    check_field("green", 16'(want.green), 16'(seen.green));
                    check_field("blue", 16'(want.blue), 16'(seen.blue));
                    check_field("alpha", 16'(want.alpha), 16'(seen.alpha));
                    check_field("run_length", 16'(want.run_length), 16'(seen.run_length));
                    check_field("image_done", 16'(want.image_done), 16'(seen.image_done));
                    check_field("image_width", want.image_width, seen.image_width);
                    check_field("image_height", want.image_height, seen.image_height);
                    case (want.status)
                        ST_RUN:         run_total++;
                        ST_UNSUPPORTED: reject_total++;
                        default:        empty_total++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser, got, want);
                if (got) decoded_due.push_back(want);
            end
        end
        error_count  <= fail_total;
        words_due    <= decoded_due.size();
        runs_seen    <= run_total;
        rejects_seen <= reject_total;
        empties_seen <= empty_total;
    end

endmodule

// ===== sim/tga_rle_decoder_tb.sv =====
module tga_rle_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import trd_pkg::*;

    localparam int BYTE_TARGET = 1950;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PIXEL_CAP   = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // data_byte[7:0]
    logic        s_tuser  = 1'b0;   // file_start[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // red, green, blue, alpha, run_length,
                                    // image_width[55:40], image_height[71:56]
    logic [1:0]  m_tuser;           // status[1:0]
    logic        m_tlast;           // image_done

    int error_count;
    int words_due;
    int runs_seen;
    int rejects_seen;
    int empties_seen;

    int idle_pct  = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int files_sent = 0;

    logic [7:0] file_q[$];

    tga_rle_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    trd_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .error_count  (error_count),
        .words_due    (words_due),
        .runs_seen    (runs_seen),
        .rejects_seen (rejects_seen),
        .empties_seen (empties_seen)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // overall run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tga_rle_decoder regression: fail");
        $finish;
    end

    // offer one word and hold it until taken
    task automatic push_byte(input logic [7:0] b, input logic fs, input bit counted);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) bytes_sent++;
    endtask

    // sender holds off until every owed word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
    endtask

    task automatic add_pixel(input int bpp, input int fill);
        repeat (bpp) file_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    // 18-byte header followed by the id field
    task automatic build_header(input logic [7:0] kind, input logic [7:0] depth,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [7:0] id_len, input logic [7:0] cmap);
        file_q.delete();
        file_q.push_back(id_len);
        file_q.push_back(cmap);
        file_q.push_back(kind);
        repeat (9) file_q.push_back(8'($urandom));
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(depth);
        file_q.push_back(8'($urandom));
        repeat (id_len) file_q.push_back(8'($urandom));
    endtask

    // pixel data, raw or as a mix of raw and repeat packets
    task automatic build_pixels(input logic [7:0] kind, input int bpp, input int rem,
                                input int fill);
        int pick;
        int n;
        int hdr;
        int take;
        if (kind != TYPE_RLE) begin
            repeat (rem) add_pixel(bpp, fill);
        end else begin
            while (rem > 0) begin
                pick = $urandom_range(9);
                if (pick < 4) begin
                    n   = $urandom_range(1, (rem < 6) ? rem : 6);
                    hdr = n - 1;
                end else if (pick < 8) begin
                    n   = $urandom_range(1, 10);
                    hdr = n + 127;
                end else begin
                    hdr = $urandom_range(255);
                end
                file_q.push_back(8'(hdr));
                if (hdr < RAW_LIMIT) begin
                    n    = hdr + 1;
                    take = (n < rem) ? n : rem;
                    repeat (take) add_pixel(bpp, fill);
                end else begin
                    n    = hdr - 127;
                    take = (n < rem) ? n : rem;
                    add_pixel(bpp, fill);
                end
                rem -= take;
            end
        end
    endtask

    // send the built file, possibly cut short, then trailing noise
    task automatic send_file(input bit start_mark, input int keep, input int junk);
        int len;
        len = (keep < 0 || keep > file_q.size()) ? file_q.size() : keep;
        for (int i = 0; i < len; i++) push_byte(file_q[i], start_mark && i == 0, 1'b1);
        repeat (junk) push_byte(8'($urandom), 1'b0, 1'b0);
        files_sent++;
    endtask

    task automatic random_file();
        logic [7:0]  kind;
        logic [7:0]  depth;
        logic [7:0]  cmap;
        logic [7:0]  id_len;
        logic [15:0] w;
        logic [15:0] h;
        longint      area;
        int          pick;
        int          keep;
        int          junk;
        bit          good;
        kind  = ($urandom_range(99) < 8) ? 8'($urandom) :
                (($urandom_range(2) != 0) ? TYPE_RLE : TYPE_RAW);
        depth = ($urandom_range(99) < 6) ? 8'($urandom) :
                (($urandom_range(1) != 0) ? DEPTH_RGBA : DEPTH_RGB);
        cmap  = ($urandom_range(99) < 5) ? 8'($urandom) : 8'd0;
        pick  = $urandom_range(99);
        w     = (pick < 4) ? 16'd0 : (pick < 7) ? 16'($urandom) : 16'($urandom_range(1, 6));
        pick  = $urandom_range(99);
        h     = (pick < 4) ? 16'd0 : (pick < 7) ? 16'($urandom) : 16'($urandom_range(1, 6));
        pick  = $urandom_range(99);
        id_len = (pick < 70) ? 8'd0 : (pick < 95) ? 8'($urandom_range(1, 4)) : 8'($urandom);
        good  = (cmap == 8'd0) && (kind == TYPE_RAW || kind == TYPE_RLE) &&
                (depth == DEPTH_RGB || depth == DEPTH_RGBA);
        build_header(kind, depth, w, h, id_len, cmap);
        area = longint'(w) * longint'(h);
        if (good && area > 0)
            build_pixels(kind, (depth == DEPTH_RGBA) ? 4 : 3,
                         (area > PIXEL_CAP) ? PIXEL_CAP : int'(area), -1);
        keep = ($urandom_range(99) < 6) ? $urandom_range(1, file_q.size()) : -1;
        junk = ($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0;
        send_file($urandom_range(99) >= 4, keep, junk);
    endtask

    // directed files covering each kind of word and the corner cases
    task automatic directed_files();
        // no start mark straight after reset, one id byte, 1x1 repeat at 32 bits
        build_header(TYPE_RLE, DEPTH_RGBA, 16'd1, 16'd1, 8'd1, 8'd0);
        file_q.push_back(8'h80);
        add_pixel(4, 0);
        send_file(1'b0, -1, 2);
        // colour map present, largest width and height reported
        build_header(TYPE_RAW, DEPTH_RGB, 16'hFFFF, 16'hFFFF, 8'd0, 8'd1);
        send_file(1'b1, -1, 1);
        // zero width with an id field that must not be skipped
        build_header(TYPE_RLE, DEPTH_RGBA, 16'd0, 16'd5, 8'd3, 8'd0);
        send_file(1'b1, -1, 0);
        // restart in the middle of a header
        build_header(TYPE_RAW, DEPTH_RGB, 16'd4, 16'd4, 8'd2, 8'd0);
        send_file(1'b1, 9, 0);
        // uncompressed 2x1, all ones
        build_header(TYPE_RAW, DEPTH_RGB, 16'd2, 16'd1, 8'd0, 8'd0);
        build_pixels(TYPE_RAW, 3, 2, 255);
        send_file(1'b1, -1, 0);
        // longest repeat clamped to three pixels
        build_header(TYPE_RLE, DEPTH_RGB, 16'd3, 16'd1, 8'd0, 8'd0);
        file_q.push_back(8'hFF);
        add_pixel(3, 0);
        send_file(1'b1, -1, 0);
        // longest raw packet, tail beyond the image never read
        build_header(TYPE_RLE, DEPTH_RGBA, 16'd2, 16'd1, 8'd0, 8'd0);
        file_q.push_back(8'h7F);
        add_pixel(4, 255);
        add_pixel(4, 0);
        send_file(1'b1, -1, 3);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // traffic phases: free flow, sparse sender, stalling receiver, both light
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            if (ph == 0) directed_files();
            while (bytes_sent < (ph + 1) * BYTE_TARGET / 4) begin
                random_file();
                if ($urandom_range(99) < 3) drain();
            end
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge aclk);

        $display("sent %0d files in %0d bytes under four traffic phases", files_sent, bytes_sent);
        $display("checked %0d pixel runs, %0d rejected headers, %0d empty images",
                 runs_seen, rejects_seen, empties_seen);
        if (error_count == 0 && words_due == 0) begin
            $display("tga_rle_decoder regression: pass");
        end else begin
            $display("tga_rle_decoder regression: fail");
        end
        $finish;
    end

endmodule

// ===== tga_rle_decoder.f =====
hw/rtl/trd_pkg.sv
hw/rtl/trd_in_stage.sv
hw/rtl/trd_core.sv
hw/rtl/trd_out_stage.sv
hw/rtl/tga_rle_decoder.sv
sim/trd_checker.sv
sim/tga_rle_decoder_tb.sv
